// ===== rtl/tpqs_pkg.sv =====
// Shared types and codes for the two-class packet queue scheduler.
// No dependencies; used by rtl/two_class_packet_queue_scheduler.sv.
`default_nettype none

package tpqs_pkg;

  // Request kinds (low bit of s_tuser)
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_QUEUED      = 3'd0,
    ST_QUEUED_DROP = 3'd1,
    ST_INVALID     = 3'd2,
    ST_HIGH_FULL   = 3'd3,
    ST_DEQUEUED    = 3'd4,
    ST_EMPTY       = 3'd5
  } status_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  localparam int LEN_BITS     = 12;
  localparam int OUT_TAG_BITS = 16;
  localparam int DROP_BITS    = 32;
  localparam int BURST_BITS   = 4;
  localparam logic [BURST_BITS-1:0] BURST_MAX = 4'd15;

endpackage

`default_nettype wire

// ===== rtl/two_class_packet_queue_scheduler.sv =====
// Top level of the two-class packet descriptor queue with strict priority,
// starvation limit and drop-oldest overflow. Uses tpqs_pkg and tpqs_ram.
`default_nettype none

// Channel    Dir  Handshake          Payload (low bit first)
// ---------  ---  -----------------  ----------------------------------------------
// s_*        in   s_tvalid/s_tready  tuser: opcode, urgent
//                                    tdata: packet_tag[16], packet_length[12], pad[4]
// m_*        out  m_tvalid/m_tready  tuser: status[3], out_high
//                                    tdata: out_tag[16], out_length[12],
//                                           high_drop_total[32], normal_drop_total[32], pad
// cfg_*      in   cfg_valid/cfg_ready cfg_data: link_enable (always ready)
//
// An enqueue request, or a dequeue that finds both queues empty, produces its result
// directly; a dequeue that pops a packet passes through S_READ, since the descriptor
// stores register their read data. A dequeue holds s_tready low while in S_READ.
// A result sits in a one-entry result stage ahead of the output register,
// so a new request is taken while the output register waits on m_tready.
// Reset (rst, synchronous) empties both queues and clears counters and the
// enable; store contents are left as they are and never read unwritten.

module two_class_packet_queue_scheduler #(
  parameter int HIGH_DEPTH       = 16,
  parameter int NORMAL_DEPTH     = 32,
  parameter int BURST_LIMIT      = 8,
  parameter int MAX_PACKET_BYTES = 280,
  parameter int TAG_BITS         = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [1:0]  s_tuser,  // [0] opcode, [1] urgent
  input  wire logic [31:0] s_tdata,  // [15:0] packet_tag, [27:16] packet_length, [31:28] zero
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [3:0]       m_tuser,  // [2:0] status, [3] out_high
  output logic [95:0]      m_tdata,  // [15:0] out_tag, [27:16] out_length,
                                     // [59:28] high_drop_total, [91:60] normal_drop_total,
                                     // [95:92] zero
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data  // link_enable
);

  localparam int LB   = tpqs_pkg::LEN_BITS;
  localparam int OTB  = tpqs_pkg::OUT_TAG_BITS;
  localparam int DB   = tpqs_pkg::DROP_BITS;
  localparam int BB   = tpqs_pkg::BURST_BITS;
  localparam int DW   = TAG_BITS + LB;
  localparam int HAW  = HIGH_DEPTH > 1 ? $clog2(HIGH_DEPTH) : 1;
  localparam int NAW  = NORMAL_DEPTH > 1 ? $clog2(NORMAL_DEPTH) : 1;
  localparam int HCW  = $clog2(HIGH_DEPTH + 1);
  localparam int NCW  = $clog2(NORMAL_DEPTH + 1);

  // ---------------------------------------------------------------- state
  tpqs_pkg::state_t state, state_next;

  logic           link_enable;
  logic [HCW-1:0] high_count;
  logic [NCW-1:0] normal_count;
  logic [HAW-1:0] high_rd, high_wr;
  logic [NAW-1:0] normal_rd, normal_wr;
  logic [BB-1:0]  burst_count;
  logic [DB-1:0]  high_drops, normal_drops;
  logic           read_high;      // pending dequeue reads the high store

  // result stage
  logic                    res_valid;
  tpqs_pkg::status_t       res_status;
  logic [OTB-1:0]          res_tag;
  logic [LB-1:0]           res_len;
  logic                    res_high;
  logic [DB-1:0]           res_hdrop, res_ndrop;

  // output register
  tpqs_pkg::status_t       out_status;
  logic [OTB-1:0]          out_tag;
  logic [LB-1:0]           out_len;
  logic                    out_high;
  logic [DB-1:0]           out_hdrop, out_ndrop;

  // ---------------------------------------------------------------- decode
  logic           in_op, in_hi;
  logic [15:0]    in_tag;
  logic [LB-1:0]  in_len;
  logic           accept, is_enq, enq_ok;
  logic           high_full, normal_full, high_ne, normal_ne, burst_hit;
  logic           sel_high, sel_normal;
  logic           h_push, h_reject, n_push, n_drop, h_pop, n_pop, deq_empty;
  logic           read_phase, out_load, produce;
  logic [DW-1:0]  wdata, h_rdata, n_rdata, rd_sel;
  logic [DB-1:0]  high_drops_next, normal_drops_next;

  assign in_op  = s_tuser[0];
  assign in_hi  = s_tuser[1];
  assign in_tag = s_tdata[15:0];
  assign in_len = s_tdata[27:16];

  assign accept  = s_tvalid && s_tready;
  assign is_enq  = (in_op == tpqs_pkg::OP_ENQUEUE);
  assign enq_ok  = link_enable && (in_len != '0) && (in_len <= LB'(MAX_PACKET_BYTES));

  assign high_full   = (high_count == HCW'(HIGH_DEPTH));
  assign normal_full = (normal_count == NCW'(NORMAL_DEPTH));
  assign high_ne     = (high_count != '0);
  assign normal_ne   = (normal_count != '0);
  assign burst_hit   = (burst_count >= BB'(BURST_LIMIT));

  // Starvation limit: a full burst yields to a waiting normal packet.
  assign sel_normal = normal_ne && (burst_hit || !high_ne);
  assign sel_high   = high_ne && !(burst_hit && normal_ne);

  assign h_push    = accept && is_enq && enq_ok && in_hi && !high_full;
  assign h_reject  = accept && is_enq && enq_ok && in_hi && high_full;
  assign n_push    = accept && is_enq && enq_ok && !in_hi;
  assign n_drop    = n_push && normal_full;   // overwrite the oldest entry
  assign h_pop     = accept && !is_enq && sel_high;
  assign n_pop     = accept && !is_enq && sel_normal;
  assign deq_empty = accept && !is_enq && !sel_high && !sel_normal;

  assign wdata = {in_len, TAG_BITS'(in_tag)};

  assign high_drops_next   = (h_reject && high_drops != '1) ? high_drops + DB'(1) : high_drops;
  assign normal_drops_next = (n_drop && normal_drops != '1) ? normal_drops + DB'(1)
                                                            : normal_drops;

  assign out_load = res_valid && (!m_tvalid || m_tready);
  assign produce  = (accept && is_enq) || deq_empty || read_phase;
  assign rd_sel   = read_high ? h_rdata : n_rdata;

  // ---------------------------------------------------------------- stores
  tpqs_ram #(.DEPTH(HIGH_DEPTH), .WIDTH(DW)) u_high_ram (
    .clk   (clk),
    .we    (h_push),
    .waddr (high_wr),
    .wdata (wdata),
    .re    (h_pop),
    .raddr (high_rd),
    .rdata (h_rdata)
  );

  tpqs_ram #(.DEPTH(NORMAL_DEPTH), .WIDTH(DW)) u_normal_ram (
    .clk   (clk),
    .we    (n_push),
    .waddr (normal_wr),
    .wdata (wdata),
    .re    (n_pop),
    .raddr (normal_rd),
    .rdata (n_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      tpqs_pkg::S_IDLE: begin
        if (h_pop || n_pop) begin
          state_next = tpqs_pkg::S_READ;
        end
      end
      tpqs_pkg::S_READ: begin
        state_next = tpqs_pkg::S_IDLE;
      end
      default: state_next = tpqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    read_phase = 1'b0;
    unique case (state)
      tpqs_pkg::S_IDLE: s_tready   = !res_valid || out_load;
      tpqs_pkg::S_READ: read_phase = 1'b1;
      default: begin
        s_tready   = 1'b0;
        read_phase = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tpqs_pkg::S_IDLE;
      link_enable    <= 1'b0;
      high_count     <= '0;
      normal_count   <= '0;
      high_rd        <= '0;
      high_wr        <= '0;
      normal_rd      <= '0;
      normal_wr      <= '0;
      burst_count    <= '0;
      high_drops     <= '0;
      normal_drops   <= '0;
      read_high      <= 1'b0;
      res_valid      <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        link_enable <= cfg_data;
      end

      // high queue: push and pop never share a request
      if (h_push) begin
        high_count <= high_count + HCW'(1);
        high_wr    <= (high_wr == HAW'(HIGH_DEPTH - 1)) ? '0 : high_wr + HAW'(1);
      end else if (h_pop) begin
        high_count <= high_count - HCW'(1);
      end
      if (h_pop) begin
        high_rd <= (high_rd == HAW'(HIGH_DEPTH - 1)) ? '0 : high_rd + HAW'(1);
      end

      // normal queue: on overflow the count holds and the read side advances
      if (n_push) begin
        normal_wr <= (normal_wr == NAW'(NORMAL_DEPTH - 1)) ? '0 : normal_wr + NAW'(1);
        if (!normal_full) begin
          normal_count <= normal_count + NCW'(1);
        end
      end else if (n_pop) begin
        normal_count <= normal_count - NCW'(1);
      end
      if (n_pop || n_drop) begin
        normal_rd <= (normal_rd == NAW'(NORMAL_DEPTH - 1)) ? '0 : normal_rd + NAW'(1);
      end

      if (h_pop) begin
        if (burst_count != tpqs_pkg::BURST_MAX) begin
          burst_count <= burst_count + BB'(1);
        end
      end else if (n_pop) begin
        burst_count <= '0;
      end

      high_drops   <= high_drops_next;
      normal_drops <= normal_drops_next;

      if (h_pop || n_pop) begin
        read_high <= h_pop;
      end

      res_valid <= produce || (res_valid && !out_load);
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (produce) begin
      res_hdrop <= high_drops_next;
      res_ndrop <= normal_drops_next;
      if (read_phase) begin
        res_status <= tpqs_pkg::ST_DEQUEUED;
        res_tag    <= OTB'(rd_sel[TAG_BITS-1:0]);
        res_len    <= rd_sel[DW-1:TAG_BITS];
        res_high   <= read_high;
      end else begin
        res_tag  <= '0;
        res_len  <= '0;
        res_high <= 1'b0;
        if (deq_empty) begin
          res_status <= tpqs_pkg::ST_EMPTY;
        end else if (!enq_ok) begin
          res_status <= tpqs_pkg::ST_INVALID;
        end else if (h_reject) begin
          res_status <= tpqs_pkg::ST_HIGH_FULL;
        end else if (n_drop) begin
          res_status <= tpqs_pkg::ST_QUEUED_DROP;
        end else begin
          res_status <= tpqs_pkg::ST_QUEUED;
        end
      end
    end
    if (out_load) begin
      out_status <= res_status;
      out_tag    <= res_tag;
      out_len    <= res_len;
      out_high   <= res_high;
      out_hdrop  <= res_hdrop;
      out_ndrop  <= res_ndrop;
    end
  end

  assign m_tuser = {out_high, out_status};
  assign m_tdata = {4'b0000, out_ndrop, out_hdrop, out_len, out_tag};

  // ---------------------------------------------------------------- checks
  a_high_bound: assert property (@(posedge clk) disable iff (rst)
    high_count <= HCW'(HIGH_DEPTH))
    else $error("high queue count above depth");

  a_normal_bound: assert property (@(posedge clk) disable iff (rst)
    normal_count <= NCW'(NORMAL_DEPTH))
    else $error("normal queue count above depth");

  a_read_stage_free: assert property (@(posedge clk) disable iff (rst)
    read_phase |-> !res_valid)
    else $error("result stage occupied during store read");

  a_enq_result: assert property (@(posedge clk) disable iff (rst)
    (accept && is_enq) |=> res_valid)
    else $error("enqueue request produced no result");

endmodule

`default_nettype wire

// ===== rtl/tpqs_ram.sv =====
// Simple dual-port descriptor store: one write port, one read port,
// read data registered. No dependencies.
`default_nettype none

module tpqs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 28
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
